// File: rtl/s2da_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Shared constants, the digit cell control word and the sequencer states.
// No dependencies.
package s2da_pkg;

  localparam int VALUE_W    = 32;
  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int STEP_BITS  = 4;
  localparam int NUM_STEPS  = VALUE_W / STEP_BITS;
  localparam int STEP_CNT_W = $clog2(NUM_STEPS);
  localparam int IDX_W      = $clog2(NUM_DIGITS);
  localparam int CHAR_W     = 6;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_FIND,
    ST_EMIT
  } state_t;

endpackage

// File: rtl/s2da_cell.sv
// One BCD digit cell of the binary to decimal shift chain.
// Takes STEP_BITS bits a cycle from its lower neighbor while ctrl.shift is set, hands its top bits upward.
// Depends on s2da_pkg.
module s2da_cell
  import s2da_pkg::*;
(
  input  logic                 clk,
  input  cell_ctrl_t           ctrl,
  input  logic [STEP_BITS-1:0] bits_in,   // first bit in time at the top
  output logic [STEP_BITS-1:0] bits_out,  // first bit in time at the top
  output logic [DIGIT_W-1:0]   digit
);

  logic [DIGIT_W-1:0] digit_next;

  always_comb begin
    logic [DIGIT_W-1:0] d;
    d = digit;
    bits_out = '0;
    for (int j = STEP_BITS - 1; j >= 0; j--) begin
      if (d >= 4'd5) begin
        d = d + 4'd3;
      end
      bits_out[j] = d[DIGIT_W-1];
      d = {d[DIGIT_W-2:0], bits_in[j]};
    end
    digit_next = d;
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.shift) begin
      digit <= digit_next;
    end
  end

endmodule

// File: rtl/signed_int_to_decimal_ascii.sv
// Top level of the signed 32-bit integer to decimal ASCII converter.
// Holds the sequencer, the magnitude register, the row of digit cells and the output word.
// Depends on s2da_pkg and s2da_cell.
//
//   channel   dir  tdata                  tuser  tlast
//   s_axis    in   [31:0] value           -      -
//   m_axis    out  [5:0] character, 0s    -      last character of the number
//
// An item is accepted, shifted through the cell row (4 bits a cycle), then its top digit
// is found, then its characters go out one per cycle while m_axis is ready (1 to 11).
// The cell row's bits per cycle set the conversion length.
// Reset clears the sequencer and the output valid flag; digit cells are cleared per item.
// A stalled m_axis holds the output word, and holds the sequencer in ST_EMIT.
module signed_int_to_decimal_ascii
  import s2da_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [5:0] character, [7:6] zero
  output logic        m_axis_tlast
);

  state_t                state, state_next;
  logic [VALUE_W-1:0]    mag, mag_next;
  logic                  sign_pend, sign_pend_next;
  logic [STEP_CNT_W-1:0] step_cnt, step_cnt_next;
  logic [IDX_W-1:0]      idx, idx_next;
  logic [IDX_W-1:0]      top_idx;
  logic [CHAR_W-1:0]     character, character_next;
  logic                  last, last_next;
  logic                  out_valid, out_valid_next;
  logic                  out_free;
  cell_ctrl_t            ctrl;

  logic [STEP_BITS-1:0] chain [NUM_DIGITS+1];
  logic [DIGIT_W-1:0]   digits [NUM_DIGITS];

  assign chain[0] = mag[VALUE_W-1 -: STEP_BITS];

  for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_cell
    s2da_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .bits_in  (chain[k]),
      .bits_out (chain[k+1]),
      .digit    (digits[k])
    );
  end

  always_comb begin
    top_idx = '0;
    for (int k = 1; k < NUM_DIGITS; k++) begin
      if (digits[k] != '0) begin
        top_idx = IDX_W'(k);
      end
    end
  end

  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    state_next     = state;
    mag_next       = mag;
    sign_pend_next = sign_pend;
    step_cnt_next  = step_cnt;
    idx_next       = idx;
    character_next = character;
    last_next      = last;
    out_valid_next = out_valid && !m_axis_tready;
    ctrl.clear     = 1'b0;
    ctrl.shift     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          sign_pend_next = s_axis_tdata[VALUE_W-1];
          mag_next       = s_axis_tdata[VALUE_W-1] ? (~s_axis_tdata + 32'd1) : s_axis_tdata;
          step_cnt_next  = '0;
          ctrl.clear     = 1'b1;
          state_next     = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.shift    = 1'b1;
        mag_next      = {mag[VALUE_W-STEP_BITS-1:0], {STEP_BITS{1'b0}}};
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == STEP_CNT_W'(NUM_STEPS - 1)) begin
          state_next = ST_FIND;
        end
      end
      ST_FIND: begin
        idx_next   = top_idx;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          if (sign_pend) begin
            character_next = CHAR_MINUS;
            last_next      = 1'b0;
            sign_pend_next = 1'b0;
          end else begin
            character_next = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digits[idx]};
            last_next      = (idx == '0);
            if (idx == '0) begin
              state_next = ST_IDLE;
            end else begin
              idx_next = idx - 1'b1;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    mag       <= mag_next;
    sign_pend <= sign_pend_next;
    step_cnt  <= step_cnt_next;
    idx       <= idx_next;
    character <= character_next;
    last      <= last_next;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(8-CHAR_W){1'b0}}, character};
  assign m_axis_tlast  = last;

endmodule
